@@ hw/rtl/srms_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// srms_pkg
// Shared types and constants for the signature routed membership sets unit.
// ----------------------------------------------------------------------------
package srms_pkg;

  localparam int DefCapacity    = 64;
  localparam int DefNumSystems  = 4;
  localparam int DefEntityBits  = 16;
  localparam int MaxSystems     = 4;

  localparam int ModeW          = 2;
  localparam int IdW            = 16;
  localparam int SigW           = 32;
  localparam int SysMaskW       = 4;

  localparam int InTdataW       = 56;
  localparam int OutTdataW      = 16;

  localparam int CfgIdxW        = 3;
  localparam int CfgDataW       = 32;
  localparam int SysCountW      = 3;

  localparam logic [CfgIdxW-1:0] CFG_SYSTEM_COUNT = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_MASK_SYS0    = 3'd1;

  typedef enum logic [ModeW-1:0] {
    MODE_ADD    = 2'd0,
    MODE_EXTEND = 2'd1,
    MODE_REDUCE = 2'd2,
    MODE_REMOVE = 2'd3
  } mode_e;

  typedef struct packed {
    logic [SysMaskW-1:0] member_mask;
    logic                removed_any;
    logic [SysMaskW-1:0] full_mask;
    logic [SysMaskW-1:0] changed_mask;
  } result_t;

endpackage : srms_pkg
`default_nettype wire

@@ hw/rtl/srms_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// srms_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module srms_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule : srms_ram
`default_nettype wire

@@ hw/rtl/signature_routed_membership_sets_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// signature_routed_membership_sets_unit
// One dense id set per system in a shared store, routed by signature masks.
// Sequence: per active system select, scan, act and, on a removal, a move-back
// write; after the last system the result is posted.
// Throughput: one item at a time, set by the single store read port scanning
// one entry per cycle; the next input transfer comes in the cycle after the
// result is posted at the earliest. The result register frees the input side early.
// Reset: counts, masks and system count clear at once; the store is not reset.
// ----------------------------------------------------------------------------
module signature_routed_membership_sets_unit #(
  parameter int CAPACITY    = srms_pkg::DefCapacity,
  parameter int NUM_SYSTEMS = srms_pkg::DefNumSystems,
  parameter int ENTITY_BITS = srms_pkg::DefEntityBits
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // cfg
  input  wire logic                           cfg_we_i,
  input  wire logic [srms_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [srms_pkg::CfgDataW-1:0]  cfg_data_i,
  // input stream
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // mode[1:0], entity_id[17:2], signature_bits[49:18], zero fill
  input  wire logic [srms_pkg::InTdataW-1:0]  s_axis_tdata,
  // output stream
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // changed_mask[3:0], full_mask[7:4], removed_any[8], member_mask[12:9], zero fill
  output logic [srms_pkg::OutTdataW-1:0]      m_axis_tdata
);

  import srms_pkg::*;

  localparam int SW    = (NUM_SYSTEMS > 1) ? $clog2(NUM_SYSTEMS) : 1;
  localparam int KW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int AW    = SW + KW;
  localparam int Depth = 2 ** AW;
  localparam int ExtW  = (ENTITY_BITS > IdW) ? ENTITY_BITS : IdW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SYS,
    ST_SEARCH,
    ST_ACT,
    ST_LAST,
    ST_DONE
  } state_e;

  state_e                 state_q;
  mode_e                  mode_q;
  logic [ENTITY_BITS-1:0] id_q;
  logic [SigW-1:0]        sig_q;
  logic [SysCountW-1:0]   sys_count_q;
  logic [SigW-1:0]        mask_q [NUM_SYSTEMS];
  logic [CW-1:0]          cnt_q  [NUM_SYSTEMS];
  logic [SysCountW-1:0]   s_q;
  logic [CW-1:0]          k_q;
  logic [CW-1:0]          pk_q;
  logic                   pend_q;
  logic                   found_q;
  logic [KW-1:0]          pos_q;
  logic [SysMaskW-1:0]    chg_q, full_q, mem_q;
  logic                   rem_q;
  logic                   out_valid_q;
  result_t                out_q;

  logic [ExtW-1:0]        id_ext;
  logic [SysCountW-1:0]   n_act;
  logic [SW-1:0]          si;
  logic [CW-1:0]          cnt_cur;
  logic [SigW-1:0]        m_cur;
  logic                   overlap, contained, ins_mode, hit, is_full;
  logic                   issue, match;
  logic [CW-1:0]          last_k;

  logic                   ram_we, ram_re;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  logic [ENTITY_BITS-1:0] ram_wdata, ram_rdata;

  assign id_ext    = ExtW'(s_axis_tdata[IdW+ModeW-1:ModeW]);
  assign n_act     = (sys_count_q > SysCountW'(NUM_SYSTEMS)) ? SysCountW'(NUM_SYSTEMS)
                                                             : sys_count_q;
  assign si        = s_q[SW-1:0];
  assign cnt_cur   = cnt_q[si];
  assign m_cur     = mask_q[si];
  assign overlap   = |(m_cur & sig_q);
  assign contained = ((m_cur & sig_q) == m_cur);
  assign ins_mode  = (mode_q == MODE_ADD) || (mode_q == MODE_EXTEND);
  assign is_full   = (cnt_cur >= CW'(CAPACITY));
  assign issue     = (k_q < cnt_cur);
  assign match     = pend_q && (ram_rdata == id_q);
  assign last_k    = cnt_cur - CW'(1);

  always_comb begin
    unique case (mode_q)
      MODE_ADD:    hit = overlap;
      MODE_EXTEND: hit = contained;
      MODE_REDUCE: hit = !contained;
      MODE_REMOVE: hit = 1'b1;
      default:     hit = 1'b0;
    endcase
  end

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = {si, k_q[KW-1:0]};
    ram_we    = 1'b0;
    ram_waddr = {si, cnt_cur[KW-1:0]};
    ram_wdata = id_q;
    unique case (state_q)
      ST_SEARCH: begin
        ram_re = issue;
      end
      ST_ACT: begin
        if (hit && found_q && !ins_mode) begin
          ram_re    = 1'b1;
          ram_raddr = {si, last_k[KW-1:0]};
        end
        if (hit && !found_q && ins_mode && !is_full) begin
          ram_we = 1'b1;
        end
      end
      ST_LAST: begin
        ram_we    = 1'b1;
        ram_waddr = {si, pos_q};
        ram_wdata = ram_rdata;
      end
      default: begin
      end
    endcase
  end

  srms_ram #(
    .WIDTH (ENTITY_BITS),
    .DEPTH (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_ADD;
      id_q        <= '0;
      sig_q       <= '0;
      sys_count_q <= '0;
      for (int s = 0; s < NUM_SYSTEMS; s++) begin
        mask_q[s] <= '0;
        cnt_q[s]  <= '0;
      end
      s_q         <= '0;
      k_q         <= '0;
      pk_q        <= '0;
      pend_q      <= 1'b0;
      found_q     <= 1'b0;
      pos_q       <= '0;
      chg_q       <= '0;
      full_q      <= '0;
      mem_q       <= '0;
      rem_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_SYSTEM_COUNT) begin
          sys_count_q <= cfg_data_i[SysCountW-1:0];
          for (int s = 0; s < NUM_SYSTEMS; s++) begin
            if (s >= int'(cfg_data_i[SysCountW-1:0])) begin
              cnt_q[s] <= '0;
            end
          end
        end
        for (int s = 0; s < NUM_SYSTEMS; s++) begin
          if (cfg_idx_i == CfgIdxW'(int'(CFG_MASK_SYS0) + s)) begin
            mask_q[s] <= cfg_data_i;
          end
        end
      end

      if (m_axis_tvalid && m_axis_tready && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            mode_q  <= mode_e'(s_axis_tdata[ModeW-1:0]);
            id_q    <= id_ext[ENTITY_BITS-1:0];
            sig_q   <= s_axis_tdata[SigW+IdW+ModeW-1:IdW+ModeW];
            s_q     <= '0;
            chg_q   <= '0;
            full_q  <= '0;
            mem_q   <= '0;
            rem_q   <= 1'b0;
            state_q <= ST_SYS;
          end
        end
        ST_SYS: begin
          k_q    <= '0;
          pend_q <= 1'b0;
          if (s_q >= n_act) begin
            state_q <= ST_DONE;
          end else begin
            state_q <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (issue) begin
            k_q <= k_q + CW'(1);
          end
          pend_q <= issue;
          pk_q   <= k_q;
          if (match) begin
            found_q <= 1'b1;
            pos_q   <= pk_q[KW-1:0];
            state_q <= ST_ACT;
          end else if (!pend_q && !issue) begin
            found_q <= 1'b0;
            state_q <= ST_ACT;
          end
        end
        ST_ACT: begin
          if (hit && !ins_mode && found_q) begin
            chg_q[si] <= 1'b1;
            rem_q     <= 1'b1;
            state_q   <= ST_LAST;
          end else begin
            state_q <= ST_SYS;
            s_q     <= s_q + SysCountW'(1);
            if (hit && ins_mode) begin
              if (found_q) begin
                mem_q[si] <= 1'b1;
              end else if (is_full) begin
                full_q[si] <= 1'b1;
              end else begin
                cnt_q[si] <= cnt_cur + CW'(1);
                chg_q[si] <= 1'b1;
                mem_q[si] <= 1'b1;
              end
            end else if (!hit && found_q) begin
              mem_q[si] <= 1'b1;
            end
          end
        end
        ST_LAST: begin
          cnt_q[si] <= last_k;
          s_q       <= s_q + SysCountW'(1);
          state_q   <= ST_SYS;
        end
        ST_DONE: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q          <= 1'b1;
            out_q.changed_mask   <= chg_q;
            out_q.full_mask      <= full_q;
            out_q.removed_any    <= rem_q;
            out_q.member_mask    <= mem_q;
            state_q              <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutTdataW'(out_q);

endmodule : signature_routed_membership_sets_unit
`default_nettype wire

@@ hw/rtl/srms_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// srms_checker
// Port-level checks on the result stream of the membership sets unit.
// ----------------------------------------------------------------------------
module srms_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           m_axis_tvalid,
  input wire logic                           m_axis_tready,
  input wire logic [srms_pkg::OutTdataW-1:0] m_axis_tdata
);

  import srms_pkg::*;

  result_t res;
  assign res = result_t'(m_axis_tdata[$bits(result_t)-1:0]);

  // hold a stalled result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_chg_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (res.changed_mask & res.full_mask) == '0)
    else $error("system both changed and refused");

  a_removed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.removed_any |->
      res.full_mask == '0 && (res.changed_mask & res.member_mask) == '0
      && res.changed_mask != '0)
    else $error("removal result inconsistent");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (res.full_mask != '0) |->
      !res.removed_any && (res.full_mask & res.member_mask) == '0)
    else $error("refused insert shows membership");

endmodule : srms_checker

bind signature_routed_membership_sets_unit srms_checker u_srms_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
